// ----- hw/rtl/wsd_pkg.sv -----
// wsd_pkg: beat types, status codes and header constants for the websocket deframer
// no dependencies; imported by wsd_parser and websocket_frame_deframer_core
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

  // frame header constants
  localparam logic [7:0] FIN_BIT        = 8'h80;
  localparam logic [3:0] OPCODE_MASK    = 4'hF;
  localparam logic [3:0] OPCODE_TEXT    = 4'h1;
  localparam logic [6:0] LEN_CODE_16    = 7'd126;
  localparam logic [6:0] LEN_CODE_64    = 7'd127;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1023;

  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_NOT_FINAL = 3'd1,
    ST_NOT_TEXT  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_TRUNCATED = 3'd5
  } wsd_status_t;

  // one raw byte of the received buffer
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } wsd_in_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    wsd_status_t status;
  } wsd_out_t;

  // parser result toward the output register
  typedef struct packed {
    logic     valid;
    wsd_out_t beat;
  } wsd_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wsd_parser.sv -----
// wsd_parser: header parse state, masking key and payload unmask for one byte per cycle while go is high
// depends on wsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        go,
  input  wire wsd_in_t     beat,
  input  wire logic [15:0] max_payload,
  output wsd_res_t         res
);

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_SKIP = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  hidx, hidx_next;
  logic        masked, masked_next;
  logic [15:0] flen, flen_next;
  logic [7:0]  key [4];
  logic [7:0]  key_next [4];
  logic [15:0] count, count_next;

  logic [7:0]  b;
  logic        last_in;
  logic [15:0] len_val;
  logic        len_masked;
  logic [16:0] count_inc;
  logic [7:0]  unmasked;

  assign b         = beat.data_byte;
  assign last_in   = beat.buffer_end;
  // length as known after this byte: short code or low byte of the 16-bit length
  assign len_val    = (phase == PH_HDR1) ? {9'd0, b[6:0]} : {flen[15:8], b};
  assign len_masked = (phase == PH_HDR1) ? b[7] : masked;
  assign count_inc  = {1'b0, count} + 17'd1;
  assign unmasked   = b ^ key[count[1:0]];

  function automatic wsd_out_t err_beat(input wsd_status_t st);
    wsd_out_t r;
    r.payload_byte  = 8'd0;
    r.last_of_frame = 1'b1;
    r.status        = st;
    return r;
  endfunction

  always_comb begin
    phase_next  = phase;
    hidx_next   = hidx;
    masked_next = masked;
    flen_next   = flen;
    count_next  = count;
    for (int i = 0; i < 4; i++) key_next[i] = key[i];
    res         = '0;

    unique case (phase)
      PH_HDR0: begin
        masked_next = 1'b0;
        flen_next   = 16'd0;
        hidx_next   = 2'd0;
        count_next  = 16'd0;
        for (int i = 0; i < 4; i++) key_next[i] = 8'd0;
        if ((b & FIN_BIT) == 8'd0) begin
          res.valid  = 1'b1;
          res.beat   = err_beat(ST_NOT_FINAL);
          phase_next = last_in ? PH_HDR0 : PH_SKIP;
        end else if ((b[3:0] & OPCODE_MASK) != OPCODE_TEXT) begin
          res.valid  = 1'b1;
          res.beat   = err_beat(ST_NOT_TEXT);
          phase_next = last_in ? PH_HDR0 : PH_SKIP;
        end else if (last_in) begin
          res.valid  = 1'b1;
          res.beat   = err_beat(ST_TRUNCATED);
          phase_next = PH_HDR0;
        end else begin
          phase_next = PH_HDR1;
        end
      end

      PH_HDR1, PH_EXT: begin
        if (phase == PH_HDR1) masked_next = b[7];
        if (phase == PH_HDR1 && b[6:0] == LEN_CODE_64) begin
          res.valid  = 1'b1;
          res.beat   = err_beat(ST_TOO_LONG);
          phase_next = last_in ? PH_HDR0 : PH_SKIP;
        end else if ((phase == PH_HDR1 && b[6:0] == LEN_CODE_16) ||
                     (phase == PH_EXT && hidx == 2'd0)) begin
          // first byte of the extended length still to come, or just taken
          if (phase == PH_HDR1) begin
            hidx_next  = 2'd0;
            phase_next = PH_EXT;
          end else begin
            flen_next = {b, 8'd0};
            hidx_next = 2'd1;
          end
          if (last_in) begin
            res.valid  = 1'b1;
            res.beat   = err_beat(ST_TRUNCATED);
            phase_next = PH_HDR0;
          end
        end else begin
          // length known: range check, then key or payload
          flen_next = len_val;
          if (len_val == 16'd0) begin
            res.valid  = 1'b1;
            res.beat   = err_beat(ST_EMPTY);
            phase_next = last_in ? PH_HDR0 : PH_SKIP;
          end else if (len_val > max_payload) begin
            res.valid  = 1'b1;
            res.beat   = err_beat(ST_TOO_LONG);
            phase_next = last_in ? PH_HDR0 : PH_SKIP;
          end else begin
            hidx_next  = 2'd0;
            count_next = 16'd0;
            if (last_in) begin
              res.valid  = 1'b1;
              res.beat   = err_beat(ST_TRUNCATED);
              phase_next = PH_HDR0;
            end else begin
              phase_next = len_masked ? PH_KEY : PH_DATA;
            end
          end
        end
      end

      PH_KEY: begin
        key_next[hidx] = b;
        hidx_next      = hidx + 2'd1;
        if (hidx == 2'd3) phase_next = PH_DATA;
        if (last_in) begin
          res.valid  = 1'b1;
          res.beat   = err_beat(ST_TRUNCATED);
          phase_next = PH_HDR0;
        end
      end

      PH_DATA: begin
        count_next = count_inc[15:0];
        res.valid  = 1'b1;
        if (count_inc >= {1'b0, flen}) begin
          res.beat.payload_byte  = unmasked;
          res.beat.last_of_frame = 1'b1;
          res.beat.status        = ST_DATA;
          phase_next             = last_in ? PH_HDR0 : PH_SKIP;
        end else if (last_in) begin
          res.beat   = err_beat(ST_TRUNCATED);
          phase_next = PH_HDR0;
        end else begin
          res.beat.payload_byte  = unmasked;
          res.beat.last_of_frame = 1'b0;
          res.beat.status        = ST_DATA;
        end
      end

      PH_SKIP: begin
        if (last_in) phase_next = PH_HDR0;
      end

      default: begin
        if (last_in) phase_next = PH_HDR0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR0;
      hidx   <= 2'd0;
      masked <= 1'b0;
      flen   <= 16'd0;
      count  <= 16'd0;
      for (int i = 0; i < 4; i++) key[i] <= 8'd0;
    end else if (go) begin
      phase  <= phase_next;
      hidx   <= hidx_next;
      masked <= masked_next;
      flen   <= flen_next;
      count  <= count_next;
      for (int i = 0; i < 4; i++) key[i] <= key_next[i];
    end
  end

  // payload bytes only while a frame of known, accepted length is open
  a_data_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (flen != 16'd0))
    else $error("payload phase with zero frame length");

  a_count_below_len: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (count < flen))
    else $error("payload count reached frame length inside payload phase");

  a_unmasked_key_zero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA && !masked) |-> (key[0] == 8'd0 && key[3] == 8'd0))
    else $error("unmasked frame with nonzero key");

endmodule

`default_nettype wire

// ----- hw/rtl/websocket_frame_deframer_core.sv -----
// websocket_frame_deframer_core: top level with input register, parser and result register
// depends on wsd_pkg and wsd_parser
`timescale 1ns / 1ps
`default_nettype none

// Receive-side WebSocket deframer for one client-to-server frame per buffer.
// Bytes of the buffer arrive one per beat on the byte channel, buffer_end marking
// the last. The header (FIN, opcode, mask bit, 7-bit or 16-bit length, masking key)
// is parsed and each payload byte leaves on the payload channel, unmasked, with
// last_of_frame on the final one. A frame that is not final, not text, empty,
// longer than max_payload, uses the 64-bit length code, or is cut short by
// buffer_end gives exactly one error beat (byte 0, last_of_frame 1, status code),
// after which the rest of the buffer is dropped up to its end byte; bytes after a
// complete frame are dropped the same way. Throughput is one byte per clock while
// payload_stall is low: a byte sits in an input register, passes the parser
// logic, and its result lands in an output register. max_payload resets to 1023;
// the user writes it only while idle, as the block itself does not enforce this.
module websocket_frame_deframer_core
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // byte channel
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire wsd_in_t     byte_beat,
  // payload channel
  output logic             payload_valid,
  input  wire logic        payload_stall,
  output wsd_out_t         payload_beat,
  // configuration
  input  wire logic        max_payload_we,
  input  wire logic [15:0] max_payload_wdata
);

  logic [15:0] max_payload;

  // input register
  logic    q_valid;
  wsd_in_t q_beat;

  // control between the stages
  logic     out_free;
  logic     go;
  logic     byte_take;
  wsd_res_t res;

  // output register can take a new beat when empty or being drained
  assign out_free   = !payload_valid || !payload_stall;
  assign go         = q_valid && out_free;
  assign byte_stall = q_valid && !out_free;
  assign byte_take  = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (max_payload_we) begin
      max_payload <= max_payload_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (byte_take) begin
      q_valid <= 1'b1;
    end else if (go) begin
      q_valid <= 1'b0;
    end
    if (byte_take) q_beat <= byte_beat;
  end

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .beat        (q_beat),
    .max_payload (max_payload),
    .res         (res)
  );

  // result register; a byte with no result just clears it once drained
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_valid <= 1'b0;
    end else if (go) begin
      payload_valid <= res.valid;
    end else if (!payload_stall) begin
      payload_valid <= 1'b0;
    end
    if (go && res.valid) payload_beat <= res.beat;
  end

  // the byte channel only backs up when a byte is held
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> q_valid)
    else $error("byte channel stalled with empty input register");

  // error beats carry a zero byte and close the frame
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    (payload_valid && payload_beat.status != ST_DATA) |->
      (payload_beat.last_of_frame && payload_beat.payload_byte == 8'd0))
    else $error("error beat without last_of_frame or with nonzero byte");

  // a held byte with a stalled full output must back up the byte channel
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (q_valid && payload_valid && payload_stall) |-> byte_stall)
    else $error("byte accepted while pipeline is blocked");

endmodule

`default_nettype wire

// ----- tb/wsd_checker.sv -----
`timescale 1ns / 1ps
// wsd_checker: watches both channels of the websocket deframer, predicts each result beat
// and compares it field by field; depends on wsd_pkg for the beat types and constants

module wsd_checker
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  wsd_in_t     byte_beat,
  input  logic        payload_valid,
  input  logic        payload_stall,
  input  wsd_out_t    payload_beat,
  input  logic        max_payload_we,
  input  logic [15:0] max_payload_wdata,
  output int          fail_count,
  output int          pending,
  output int          data_beats,
  output int          error_beats
);

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA, PH_SKIP
  } parse_phase_t;

  parse_phase_t phase;
  logic [15:0]  max_len;
  logic [2:0]   hidx;
  logic         fin_seen;
  logic [3:0]   opcode;
  logic         masked;
  logic [15:0]  frame_len;
  logic [7:0]   key_bytes [4];
  logic [15:0]  byte_count;
  wsd_out_t     predicted_beats [$];

  task automatic reset_parser();
    max_len = MAX_PAYLOAD_RESET;
    phase = PH_HDR0;
    hidx = '0;
    fin_seen = 1'b0;
    opcode = '0;
    masked = 1'b0;
    frame_len = '0;
    byte_count = '0;
    foreach (key_bytes[i]) key_bytes[i] = 8'h00;
  endtask

  task automatic push_beat(input logic [7:0] v, input logic lst, input wsd_status_t st);
    wsd_out_t beat;
    beat.payload_byte = v;
    beat.last_of_frame = lst;
    beat.status = st;
    predicted_beats.push_back(beat);
  endtask

  // error beat; keep skipping unless this byte closed the buffer
  task automatic push_error(input wsd_status_t st, input logic last_in);
    phase = last_in ? PH_HDR0 : PH_SKIP;
    push_beat(8'h00, 1'b1, st);
  endtask

  task automatic length_done(input logic last_in);
    if (frame_len == 16'd0) begin
      push_error(ST_EMPTY, last_in);
    end else if (frame_len > max_len) begin
      push_error(ST_TOO_LONG, last_in);
    end else begin
      hidx = '0;
      byte_count = '0;
      phase = masked ? PH_KEY : PH_DATA;
      if (last_in) push_error(ST_TRUNCATED, 1'b1);
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last_in);
    logic [6:0] code;
    logic [7:0] v;
    case (phase)
      PH_HDR0: begin
        fin_seen = (b & FIN_BIT) != 8'h00;
        opcode = b[3:0] & OPCODE_MASK;
        masked = 1'b0;
        frame_len = '0;
        hidx = '0;
        byte_count = '0;
        foreach (key_bytes[i]) key_bytes[i] = 8'h00;
        if (!fin_seen) begin
          push_error(ST_NOT_FINAL, last_in);
        end else if (opcode != OPCODE_TEXT) begin
          push_error(ST_NOT_TEXT, last_in);
        end else begin
          phase = PH_HDR1;
          if (last_in) push_error(ST_TRUNCATED, 1'b1);
        end
      end
      PH_HDR1: begin
        masked = b[7];
        code = b[6:0];
        if (code == LEN_CODE_64) begin
          push_error(ST_TOO_LONG, last_in);
        end else if (code == LEN_CODE_16) begin
          hidx = '0;
          phase = PH_EXT;
          if (last_in) push_error(ST_TRUNCATED, 1'b1);
        end else begin
          frame_len = {9'd0, code};
          length_done(last_in);
        end
      end
      PH_EXT: begin
        if (hidx == 3'd0) begin
          frame_len = {b, 8'h00};
          hidx = 3'd1;
          if (last_in) push_error(ST_TRUNCATED, 1'b1);
        end else begin
          frame_len = frame_len | {8'h00, b};
          length_done(last_in);
        end
      end
      PH_KEY: begin
        key_bytes[hidx[1:0]] = b;
        hidx = hidx + 3'd1;
        if (hidx >= 3'd4) begin
          hidx = '0;
          phase = PH_DATA;
        end
        if (last_in) push_error(ST_TRUNCATED, 1'b1);
      end
      PH_DATA: begin
        v = b ^ key_bytes[byte_count[1:0]];
        byte_count = byte_count + 16'd1;
        if (byte_count >= frame_len) begin
          phase = last_in ? PH_HDR0 : PH_SKIP;
          push_beat(v, 1'b1, ST_DATA);
        end else if (last_in) begin
          push_error(ST_TRUNCATED, 1'b1);
        end else begin
          push_beat(v, 1'b0, ST_DATA);
        end
      end
      default: begin
        if (last_in) phase = PH_HDR0;
      end
    endcase
  endtask

  task automatic check_beat(input wsd_out_t got);
    wsd_out_t want;
    if (predicted_beats.size() == 0) begin
      if (fail_count < 10)
        $display("%0t: unexpected beat byte=%02h last=%0b status=%0d", $realtime,
                 got.payload_byte, got.last_of_frame, got.status);
      fail_count++;
    end else begin
      want = predicted_beats.pop_front();
      if (want.status == ST_DATA) data_beats++;
      else error_beats++;
      if (got.payload_byte !== want.payload_byte || got.last_of_frame !== want.last_of_frame ||
          got.status !== want.status) begin
        if (fail_count < 10)
          $display("%0t: beat mismatch exp byte=%02h last=%0b status=%0d, got byte=%02h last=%0b status=%0d",
                   $realtime, want.payload_byte, want.last_of_frame, want.status,
                   got.payload_byte, got.last_of_frame, got.status);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reset_parser();
      predicted_beats.delete();
      fail_count = 0;
      data_beats = 0;
      error_beats = 0;
    end else begin
      if (payload_valid && !payload_stall) check_beat(payload_beat);
      if (max_payload_we) max_len = max_payload_wdata;
      if (byte_valid && !byte_stall) parse_byte(byte_beat.data_byte, byte_beat.buffer_end);
    end
    pending = predicted_beats.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for websocket_frame_deframer_core
// depends on wsd_pkg, the deframer rtl and wsd_checker

module tb_top;
  import wsd_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  wsd_in_t     byte_beat;
  logic        payload_valid;
  logic        payload_stall;
  wsd_out_t    payload_beat;
  logic        max_payload_we;
  logic [15:0] max_payload_wdata;

  // idling switches and the long receiver hold-off handshake
  logic tx_idle_en;
  logic rx_idle_en;
  int   hold_req_cnt;
  int   hold_done_cnt;

  int fail_count, pending, data_beats, error_beats;
  int bytes_sent;
  int settings_used;
  int cycle_cnt;

  // shadow of max_payload, only used to aim frame lengths at the limit
  logic [15:0] cur_max;
  // bytes of the buffer being sent, buffer_end goes on the last one
  logic [7:0]  frame_q [$];

  always #1 clk = ~clk;

  websocket_frame_deframer_core u_dut (
    .clk               (clk),
    .rst               (rst),
    .byte_valid        (byte_valid),
    .byte_stall        (byte_stall),
    .byte_beat         (byte_beat),
    .payload_valid     (payload_valid),
    .payload_stall     (payload_stall),
    .payload_beat      (payload_beat),
    .max_payload_we    (max_payload_we),
    .max_payload_wdata (max_payload_wdata)
  );

  wsd_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .byte_valid        (byte_valid),
    .byte_stall        (byte_stall),
    .byte_beat         (byte_beat),
    .payload_valid     (payload_valid),
    .payload_stall     (payload_stall),
    .payload_beat      (payload_beat),
    .max_payload_we    (max_payload_we),
    .max_payload_wdata (max_payload_wdata),
    .fail_count        (fail_count),
    .pending           (pending),
    .data_beats        (data_beats),
    .error_beats       (error_beats)
  );

  // watchdog: a hung handshake or a lost beat ends here
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d beats still expected", cycle_cnt, pending);
    $display("Regression FAIL");
    $finish;
  end

  // payload receiver: random stall bursts, plus one long hold-off when asked
  initial begin
    payload_stall = 1'b0;
    hold_done_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_done_cnt != hold_req_cnt) begin
        payload_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        payload_stall <= 1'b0;
        hold_done_cnt++;
      end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
        payload_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        payload_stall <= 1'b0;
      end
    end
  end

  // sends frame_q as one buffer; valid stays high between back-to-back beats
  task automatic send_buffer();
    int gap;
    for (int i = 0; i < frame_q.size(); i++) begin
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 15);
        byte_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      byte_beat.data_byte  <= frame_q[i];
      byte_beat.buffer_end <= (i == frame_q.size() - 1);
      byte_valid           <= 1'b1;
      @(posedge clk);
      while (byte_stall) @(posedge clk);
      bytes_sent++;
      @(negedge clk);
    end
  endtask

  // sender goes quiet until every predicted beat has come back
  task automatic drain();
    byte_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // a header or skipped byte may still sit in the two-stage pipe
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_max(input logic [15:0] v);
    max_payload_wdata <= v;
    max_payload_we    <= 1'b1;
    @(negedge clk);
    max_payload_we    <= 1'b0;
    cur_max = v;
    settings_used++;
  endtask

  // lengths cluster around empty, the limit and just past it
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 16'd0;
      1:       return (cur_max <= 16'd300) ? cur_max : 16'($urandom_range(1, 30));
      2:       return (cur_max < 16'd300) ? cur_max + 16'd1 : 16'($urandom);
      3:       return 16'($urandom_range(126, 300));
      default: return 16'($urandom_range(1, 30));
    endcase
  endfunction

  // mostly well-formed text frames with random content, some noise and cut buffers
  task automatic build_random_frame();
    int          kind;
    int          body;
    int          cut;
    logic        mask_on;
    logic [15:0] flen;
    frame_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      // pure noise buffer
      repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
    end else begin
      if (kind < 16) frame_q.push_back(8'($urandom));
      else frame_q.push_back({1'b1, 3'($urandom), OPCODE_TEXT});
      mask_on = ($urandom_range(0, 3) != 0);
      flen = pick_length();
      if ($urandom_range(0, 29) == 0) begin
        // 64-bit length code followed by a fake length
        frame_q.push_back({mask_on, LEN_CODE_64});
        repeat (8) frame_q.push_back(8'($urandom));
      end else if (flen > 16'd125 || $urandom_range(0, 4) == 0) begin
        frame_q.push_back({mask_on, LEN_CODE_16});
        frame_q.push_back(flen[15:8]);
        frame_q.push_back(flen[7:0]);
      end else begin
        frame_q.push_back({mask_on, flen[6:0]});
      end
      if (mask_on) repeat (4) frame_q.push_back(8'($urandom));
      // huge lengths get a short body, so they end as truncated or too long
      body = (flen > 16'd300) ? $urandom_range(0, 10) : int'(flen);
      repeat (body) frame_q.push_back(8'($urandom));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      if (frame_q.size() > 1 && $urandom_range(0, 6) == 0) begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
    end
  endtask

  task automatic run_random(input int nbytes);
    int target;
    target = bytes_sent + nbytes;
    while (bytes_sent < target) begin
      build_random_frame();
      send_buffer();
    end
  endtask

  initial begin
    rst               = 1'b1;
    byte_valid        = 1'b0;
    byte_beat         = '0;
    max_payload_we    = 1'b0;
    max_payload_wdata = '0;
    tx_idle_en        = 1'b0;
    rx_idle_en        = 1'b0;
    hold_req_cnt      = 0;
    bytes_sent        = 0;
    settings_used     = 0;
    cur_max           = MAX_PAYLOAD_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed buffers at the reset limit of 1023
    // not final and not text together: not final wins, error on the end byte
    frame_q = '{8'h02};
    send_buffer();
    // final but binary opcode, rest of the buffer skipped
    frame_q = '{8'h82, 8'hFF, 8'h00};
    send_buffer();
    // masked frame of length zero
    frame_q = '{8'h81, 8'h80};
    send_buffer();
    // 64-bit length code is rejected as too long
    frame_q = '{8'h81, 8'hFF, 8'h55};
    send_buffer();
    // unmasked two-byte frame, bytes after it dropped silently
    frame_q = '{8'h81, 8'h02, 8'h41, 8'h42, 8'h99, 8'h98};
    send_buffer();
    // masked one-byte frame whose last payload byte ends the buffer
    frame_q = '{8'h81, 8'h81, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h00};
    send_buffer();
    // buffer ends on the first header byte
    frame_q = '{8'h81};
    send_buffer();
    // buffer ends inside the 16-bit length
    frame_q = '{8'h81, 8'hFE, 8'hFF};
    send_buffer();
    drain();

    // random traffic at the reset limit, both sides idling
    tx_idle_en <= 1'b1;
    rx_idle_en <= 1'b1;
    run_random(350);
    drain();

    // limit of zero: every non-empty frame is too long
    write_max(16'd0);
    run_random(100);
    drain();

    // widest limit: full 16-bit length cut short, then a long receiver hold-off
    write_max(16'hFFFF);
    frame_q = '{8'h81, 8'h7E, 8'hFF, 8'hFF};
    repeat (12) frame_q.push_back(8'($urandom));
    send_buffer();
    hold_req_cnt <= hold_req_cnt + 1;
    frame_q = '{8'h81, 8'hE4};
    repeat (104) frame_q.push_back(8'($urandom));
    send_buffer();
    run_random(300);
    drain();

    // small random limit, lengths aimed at its edge
    write_max(16'($urandom_range(4, 40)));
    run_random(200);
    drain();

    // back to the default limit with no idling at all
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    write_max(MAX_PAYLOAD_RESET);
    run_random(150);
    drain();

    $display("sent %0d buffer bytes under %0d max_payload settings plus the reset value",
             bytes_sent, settings_used);
    $display("checked %0d payload beats and %0d error beats", data_beats, error_beats);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
